// ===== sv/assert_macros.svh =====
// Shared assertion macros for the frame receiver checks.
// Each macro expands to one labeled concurrent assertion that is disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== sv/crsf_pkg.sv =====
// ---------------------------------------------------------------------------
// CRSF receiver package
// Shared constants, types and the CRC-8 step used by the frame receiver.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package crsf_pkg;

  // Frame and channel layout.
  localparam int NUM_CHANNELS  = 16;
  localparam int CH_BITS       = 11;
  localparam int PAYLOAD_BYTES = (NUM_CHANNELS * CH_BITS + 7) / 8;
  localparam int SHORT_LEN     = PAYLOAD_BYTES + 2;

  localparam logic [7:0] RC_TYPE  = 8'h16;
  localparam logic [7:0] CRC_POLY = 8'hD5;

  // Configuration register reset values.
  localparam logic [7:0] SYNC_PRI_RST = 8'hC8;
  localparam logic [7:0] SYNC_SEC_RST = 8'hEE;
  localparam logic [6:0] MAX_LEN_RST  = 7'd64;

  // Configuration register indexes.
  localparam logic [1:0] REG_SYNC_PRI = 2'd0;
  localparam logic [1:0] REG_SYNC_SEC = 2'd1;
  localparam logic [1:0] REG_MAX_LEN  = 2'd2;

  // Result kinds.
  localparam logic [1:0] KIND_VALUE = 2'd0;
  localparam logic [1:0] KIND_CRC   = 2'd1;
  localparam logic [1:0] KIND_SHORT = 2'd2;

  // Parser phases.
  typedef enum logic [1:0] {
    PH_HUNT,
    PH_LEN,
    PH_TYPE,
    PH_BODY
  } phase_e;

  // Commands passed from the parser to the result emitter.
  typedef enum logic [1:0] {
    CMD_CHANNELS,
    CMD_CRC_ERR,
    CMD_SHORT
  } cmd_e;

  // Live configuration seen by the parser.
  typedef struct packed {
    logic [7:0] sync_pri;
    logic [7:0] sync_sec;
    logic [6:0] max_len;
  } cfg_t;

  // One write into the channel store.
  typedef struct packed {
    logic                 en;
    logic [3:0]           idx;
    logic [CH_BITS-1:0]   data;
  } store_wr_t;

  // One CRC-8 step over a full byte, MSB first.
  function automatic logic [7:0] crc8_d5(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

// ===== sv/crsf_if.sv =====
// ---------------------------------------------------------------------------
// CRSF receiver channels
// Valid/ready channel bundles for received bytes and for results.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface crsf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface crsf_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [3:0]  channel_index;
  logic [10:0] channel_value;
  logic        last;

  modport source (output valid, output kind, output channel_index, output channel_value,
                  output last, input ready);
  modport sink (input valid, input kind, input channel_index, input channel_value,
                input last, output ready);
endinterface

// ===== sv/crsf_front.sv =====
// ---------------------------------------------------------------------------
// CRSF frame parser
// Takes one byte per transfer, tracks sync, length and type, runs the CRC
// and unpacks channel bits into the store; posts a command at the end of an RC frame.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module crsf_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  crsf_pkg::cfg_t      cfg_i,
  input  logic                in_valid_i,
  input  logic [7:0]          in_byte_i,
  output logic                in_ready_o,
  input  logic                back_busy_i,
  input  logic                cmd_full_i,
  output logic                cmd_push_o,
  output crsf_pkg::cmd_e      cmd_o,
  output crsf_pkg::store_wr_t store_wr_o
);
  import crsf_pkg::*;

  phase_e      phase_q, phase_d;
  logic [6:0]  left_q, left_d;
  logic        rc_q, rc_d;
  logic [6:0]  len_q, len_d;
  logic [7:0]  crc_q, crc_d;
  logic [18:0] acc_q, acc_d;
  logic [4:0]  held_q, held_d;
  logic [4:0]  pidx_q, pidx_d;
  logic [4:0]  ch_q, ch_d;

  logic        accept;
  logic        is_sync;
  logic [18:0] acc_tmp;
  logic [4:0]  held_tmp;

  // Body bytes of an RC frame wait while the emitter still reads the store.
  assign in_ready_o = !cmd_full_i && !(phase_q == PH_BODY && rc_q && back_busy_i);
  assign accept     = in_valid_i && in_ready_o;
  assign is_sync    = (in_byte_i == cfg_i.sync_pri) || (in_byte_i == cfg_i.sync_sec);

  // Parser state register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      left_q  <= '0;
      rc_q    <= 1'b0;
      len_q   <= '0;
      crc_q   <= '0;
      acc_q   <= '0;
      held_q  <= '0;
      pidx_q  <= '0;
      ch_q    <= '0;
    end else begin
      phase_q <= phase_d;
      left_q  <= left_d;
      rc_q    <= rc_d;
      len_q   <= len_d;
      crc_q   <= crc_d;
      acc_q   <= acc_d;
      held_q  <= held_d;
      pidx_q  <= pidx_d;
      ch_q    <= ch_d;
    end
  end

  // Next state, store writes and frame-end commands.
  always_comb begin
    phase_d    = phase_q;
    left_d     = left_q;
    rc_d       = rc_q;
    len_d      = len_q;
    crc_d      = crc_q;
    acc_d      = acc_q;
    held_d     = held_q;
    pidx_d     = pidx_q;
    ch_d       = ch_q;
    cmd_push_o = 1'b0;
    cmd_o      = CMD_CRC_ERR;
    store_wr_o = '0;
    acc_tmp    = acc_q | (19'(in_byte_i) << held_q);
    held_tmp   = held_q + 5'd8;

    if (accept) begin
      unique case (phase_q)
        PH_LEN: begin
          if (in_byte_i >= 8'd2 && in_byte_i <= {1'b0, cfg_i.max_len}) begin
            len_d   = in_byte_i[6:0];
            left_d  = in_byte_i[6:0];
            phase_d = PH_TYPE;
          end else begin
            phase_d = is_sync ? PH_LEN : PH_HUNT;
          end
        end
        PH_TYPE: begin
          rc_d    = (in_byte_i == RC_TYPE);
          crc_d   = crc8_d5(8'd0, in_byte_i);
          acc_d   = '0;
          held_d  = '0;
          pidx_d  = '0;
          ch_d    = '0;
          left_d  = left_q - 7'd1;
          phase_d = PH_BODY;
        end
        PH_BODY: begin
          if (left_q <= 7'd1) begin
            // CRC byte closes the frame.
            phase_d = PH_HUNT;
            left_d  = '0;
            if (rc_q) begin
              cmd_push_o = 1'b1;
              if (len_q < 7'(SHORT_LEN)) begin
                cmd_o = CMD_SHORT;
              end else if (crc_q == in_byte_i) begin
                cmd_o = CMD_CHANNELS;
              end else begin
                cmd_o = CMD_CRC_ERR;
              end
            end
          end else begin
            crc_d  = crc8_d5(crc_q, in_byte_i);
            left_d = left_q - 7'd1;
            // Unpack channel bits LSB first while inside the channel payload.
            if (rc_q && pidx_q < 5'(PAYLOAD_BYTES)) begin
              pidx_d = pidx_q + 5'd1;
              if (held_tmp >= 5'(CH_BITS)) begin
                store_wr_o.en   = (ch_q < 5'(NUM_CHANNELS));
                store_wr_o.idx  = ch_q[3:0];
                store_wr_o.data = acc_tmp[CH_BITS-1:0];
                ch_d            = ch_q + 5'd1;
                acc_d           = acc_tmp >> CH_BITS;
                held_d          = held_tmp - 5'(CH_BITS);
              end else begin
                acc_d  = acc_tmp;
                held_d = held_tmp;
              end
            end
          end
        end
        PH_HUNT: begin
          phase_d = is_sync ? PH_LEN : PH_HUNT;
        end
        default: begin
          phase_d = PH_HUNT;
        end
      endcase
    end
  end

endmodule

// ===== sv/crsf_cmd_fifo.sv =====
// ---------------------------------------------------------------------------
// CRSF command queue
// Two-entry queue of frame-end commands between parser and emitter.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module crsf_cmd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  crsf_pkg::cmd_e push_cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output crsf_pkg::cmd_e head_o
);
  import crsf_pkg::*;

  cmd_e       mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] count_q;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign head_o  = mem_q[rptr_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= '0;
    end else begin
      if (push_i) wptr_q <= ~wptr_q;
      if (pop_i)  rptr_q <= ~rptr_q;
      count_q <= count_q + 2'(push_i) - 2'(pop_i);
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_cmd_i;
    end
  end

endmodule

// ===== sv/crsf_back.sv =====
// ---------------------------------------------------------------------------
// CRSF result emitter
// Holds the channel store, pops frame-end commands and drives results
// through an output register, one result per transfer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module crsf_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  crsf_pkg::store_wr_t store_wr_i,
  input  logic                cmd_empty_i,
  input  crsf_pkg::cmd_e      cmd_i,
  output logic                cmd_pop_o,
  output logic                busy_o,
  crsf_out_if.source          out_o
);
  import crsf_pkg::*;

  localparam logic [3:0] LAST_CH = 4'(NUM_CHANNELS - 1);

  logic [CH_BITS-1:0] store_q [NUM_CHANNELS];

  logic               active_q;
  logic [3:0]         cnt_q;
  logic               valid_q;
  logic [1:0]         kind_q;
  logic [3:0]         index_q;
  logic [CH_BITS-1:0] value_q;
  logic               last_q;
  logic               adv;

  // The output register may load when it is empty or being taken.
  assign adv       = !valid_q || out_o.ready;
  assign cmd_pop_o = !active_q && !cmd_empty_i && adv;
  assign busy_o    = active_q || !cmd_empty_i;

  assign out_o.valid         = valid_q;
  assign out_o.kind          = kind_q;
  assign out_o.channel_index = index_q;
  assign out_o.channel_value = value_q;
  assign out_o.last          = last_q;

  // Channel store, written by the parser.
  always_ff @(posedge clk_i) begin
    if (store_wr_i.en) begin
      store_q[store_wr_i.idx] <= store_wr_i.data;
    end
  end

  // Burst control and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      cnt_q    <= '0;
      valid_q  <= 1'b0;
    end else if (active_q) begin
      if (adv) begin
        valid_q <= 1'b1;
        cnt_q   <= cnt_q + 4'd1;
        if (cnt_q == LAST_CH) active_q <= 1'b0;
      end
    end else if (cmd_pop_o) begin
      if (cmd_i == CMD_CHANNELS) begin
        active_q <= 1'b1;
        cnt_q    <= '0;
        valid_q  <= 1'b0;
      end else begin
        valid_q <= 1'b1;
      end
    end else if (adv) begin
      valid_q <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (active_q && adv) begin
      kind_q  <= KIND_VALUE;
      index_q <= cnt_q;
      value_q <= store_q[cnt_q];
      last_q  <= (cnt_q == LAST_CH);
    end else if (!active_q && cmd_pop_o && cmd_i != CMD_CHANNELS) begin
      kind_q  <= (cmd_i == CMD_SHORT) ? KIND_SHORT : KIND_CRC;
      index_q <= '0;
      value_q <= '0;
      last_q  <= 1'b1;
    end
  end

endmodule

// ===== sv/crsf_rc_frame_receiver.sv =====
// ---------------------------------------------------------------------------
// CRSF RC-channels frame receiver
// Parses a serial byte stream into RC channel results with CRC check.
// ---------------------------------------------------------------------------
// Usage:
//   in_i carries one received byte per transfer; out_o carries results of
//   kind channel value, CRC mismatch or short RC frame, with last set on
//   the final result of a frame. Registers are written through cfg_we_i,
//   cfg_idx_i and cfg_data_i; the user must write them only while the block
//   is idle, which the block does not enforce; index 3 is ignored. The parser
//   takes one byte per cycle while in_i is ready. At the CRC byte of an RC
//   frame it posts a command to a two-entry queue. An error result passes
//   from the queue into the output register; a good frame's sixteen channel
//   results pass from the queue through the emitter burst state into the
//   output register, one per cycle while out_o is ready. Body bytes of the
//   next RC frame are held off while the emitter still reads the channel
//   store, so at most one channel burst is in flight; other bytes flow at
//   one per cycle while the queue has room. A stalled receiver stalls the
//   emitter, then the queue, then in_i. Reset restores the register
//   defaults and returns the parser to sync hunting with no results pending.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module crsf_rc_frame_receiver (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  crsf_in_if.sink    in_i,
  crsf_out_if.source out_o
);
  import crsf_pkg::*;

  cfg_t      cfg_q;
  logic      cmd_push, cmd_pop, cmd_full, cmd_empty, back_busy;
  cmd_e      push_cmd, head_cmd;
  store_wr_t store_wr;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_pri <= SYNC_PRI_RST;
      cfg_q.sync_sec <= SYNC_SEC_RST;
      cfg_q.max_len  <= MAX_LEN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SYNC_PRI: cfg_q.sync_pri <= cfg_data_i;
        REG_SYNC_SEC: cfg_q.sync_sec <= cfg_data_i;
        REG_MAX_LEN:  cfg_q.max_len  <= cfg_data_i[6:0];
        default:      cfg_q          <= cfg_q;
      endcase
    end
  end

  crsf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_i.valid),
    .in_byte_i   (in_i.rx_byte),
    .in_ready_o  (in_i.ready),
    .back_busy_i (back_busy),
    .cmd_full_i  (cmd_full),
    .cmd_push_o  (cmd_push),
    .cmd_o       (push_cmd),
    .store_wr_o  (store_wr)
  );

  crsf_cmd_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (cmd_push),
    .push_cmd_i (push_cmd),
    .full_o     (cmd_full),
    .pop_i      (cmd_pop),
    .empty_o    (cmd_empty),
    .head_o     (head_cmd)
  );

  crsf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .store_wr_i  (store_wr),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (head_cmd),
    .cmd_pop_o   (cmd_pop),
    .busy_o      (back_busy),
    .out_o       (out_o)
  );

endmodule

// ===== sv/crsf_checker.sv =====
// ---------------------------------------------------------------------------
// CRSF receiver port checker
// Checks result framing and output handshake as seen on the top-level ports.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module crsf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [1:0]  out_kind_i,
  input logic [3:0]  out_index_i,
  input logic [10:0] out_value_i,
  input logic        out_last_i
);
  import crsf_pkg::*;

  logic        kind_ok;
  logic        err_zero;
  logic        top_ch;
  logic [17:0] result_bits;

  // Result fields, condensed for the checks below.
  assign kind_ok     = (out_kind_i == KIND_VALUE) || (out_kind_i == KIND_CRC) ||
                       (out_kind_i == KIND_SHORT);
  assign err_zero    = out_last_i && (out_index_i == 4'd0) && (out_value_i == 11'd0);
  assign top_ch      = (out_index_i == 4'(NUM_CHANNELS - 1));
  assign result_bits = {out_kind_i, out_index_i, out_value_i, out_last_i};

  // Only the three defined result kinds appear.
  `ASSERT_SAME(a_kind_known, clk_i, rst_ni, out_valid_i, kind_ok)

  // Error results are single, zero-filled and close their frame.
  `ASSERT_SAME(a_err_shape, clk_i, rst_ni, out_valid_i && out_kind_i != KIND_VALUE, err_zero)

  // A channel burst ends exactly at the top channel.
  `ASSERT_SAME(a_burst_end, clk_i, rst_ni, out_valid_i && out_kind_i == KIND_VALUE, out_last_i == top_ch)

  // A stalled result keeps its contents.
  `ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(result_bits))

endmodule

bind crsf_rc_frame_receiver crsf_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_kind_i  (out_o.kind),
  .out_index_i (out_o.channel_index),
  .out_value_i (out_o.channel_value),
  .out_last_i  (out_o.last)
);
